FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertions on clk with rst_n low disabling the check.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HDH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HDH_ASSERT(lbl, prop, msg)
`define HDH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: src/hdh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Height difference histogram package
// Shared constants, command and register codes, queue item and state types.
// ---------------------------------------------------------------------------
package hdh_pkg;

  localparam int BINS_DEFAULT = 256;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] REG_BIN_COUNT   = 2'd0;
  localparam logic [1:0] REG_ZERO_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BIN_SCALE   = 2'd2;

  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } hdh_op_t;

  typedef struct packed {
    hdh_op_t    op;
    logic       ignored;
    logic       zero_count;
    logic [7:0] res_bin;
  } hdh_ctl_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_RUN,
    BK_CLEAR
  } hdh_bk_state_t;

endpackage

FILE: src/hdh_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Histogram front end
// Holds the configuration registers, takes items, forms the height
// difference, scales and rounds it, clamps the bin and queues the item.
// ---------------------------------------------------------------------------
module hdh_front #(
  parameter int BINS = hdh_pkg::BINS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [1:0]                in_command,
  input  logic signed [31:0]        in_top_height,
  input  logic signed [31:0]        in_bottom_height,
  input  logic [7:0]                in_read_bin,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_wdata,
  input  logic [hdh_pkg::QCNT_W-1:0] q_count,
  output logic                      full,
  output logic                      push,
  output hdh_pkg::hdh_ctl_t         push_ctl,
  output logic [$clog2(BINS)-1:0]   push_addr
);
  import hdh_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

  logic [8:0]         bin_count_r;
  logic signed [31:0] zero_height_r;
  logic [31:0]        bin_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r   <= '0;
      zero_height_r <= '0;
      bin_scale_r   <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIN_COUNT:   bin_count_r   <= cfg_wdata[8:0];
        REG_ZERO_HEIGHT: zero_height_r <= cfg_wdata;
        REG_BIN_SCALE:   bin_scale_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: difference and bins in use
  logic              v1_r, v1_nxt;
  logic [1:0]        cmd1_r;
  logic signed [34:0] d1_r, d1_nxt;
  logic [7:0]        rb1_r;
  logic              ign1_r, ign1_nxt;
  logic [AW-1:0]     last1_r, last1_nxt;
  logic [CW-1:0]     n_bins;

  // stage 2: partial products and classification
  logic              v2_r;
  hdh_op_t           op2_r, op2_nxt;
  logic              ign2_r, ign2_nxt;
  logic              neg2_r;
  logic [49:0]       hi2_r, hi2_nxt;
  logic [49:0]       lo2_r, lo2_nxt;
  logic [AW-1:0]     last2_r;
  logic [AW-1:0]     raddr2_r, raddr2_nxt;
  logic              zc2_r, zc2_nxt;
  logic [7:0]        rb2_r;
  logic [31:0]       rb32;

  logic [QCNT_W:0]   credit_use;
  logic [66:0]       total;
  logic [34:0]       q_bin;
  logic [34:0]       q_last;
  logic [AW-1:0]     k_bin;
  logic [31:0]       k32;

  always_comb begin
    credit_use = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(v1_r) + (QCNT_W + 1)'(v2_r);
    full       = credit_use >= (QCNT_W + 1)'(QUEUE_DEPTH);
  end

  always_comb begin
    n_bins    = (CW'(bin_count_r) > CW'(BINS)) ? CW'(BINS) : CW'(bin_count_r);
    ign1_nxt  = n_bins < CW'(2);
    last1_nxt = AW'(n_bins - CW'(1));
    d1_nxt    = {{3{in_top_height[31]}}, in_top_height}
              - {{3{in_bottom_height[31]}}, in_bottom_height}
              - {{3{zero_height_r[31]}}, zero_height_r};
    v1_nxt    = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd1_r  <= in_command;
      d1_r    <= d1_nxt;
      rb1_r   <= in_read_bin;
      ign1_r  <= ign1_nxt;
      last1_r <= last1_nxt;
    end
  end

  always_comb begin
    hi2_nxt    = {16'b0, d1_r[33:0]} * {34'b0, bin_scale_r[31:16]};
    lo2_nxt    = {16'b0, d1_r[33:0]} * {34'b0, bin_scale_r[15:0]};
    rb32       = {24'b0, rb1_r};
    raddr2_nxt = rb32[AW-1:0];
    zc2_nxt    = rb32 >= 32'(BINS);
    ign2_nxt   = 1'b0;
    unique case (cmd1_r)
      CMD_SAMPLE: begin
        op2_nxt  = ign1_r ? OP_NOP : OP_SAMPLE;
        ign2_nxt = ign1_r;
      end
      CMD_CLEAR: op2_nxt = OP_CLEAR;
      CMD_READ:  op2_nxt = OP_READ;
      default:   op2_nxt = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      op2_r    <= op2_nxt;
      ign2_r   <= ign2_nxt;
      neg2_r   <= d1_r[34];
      hi2_r    <= hi2_nxt;
      lo2_r    <= lo2_nxt;
      last2_r  <= last1_r;
      raddr2_r <= raddr2_nxt;
      zc2_r    <= zc2_nxt;
      rb2_r    <= rb1_r;
    end
  end

  // round half up, then clamp to the bins in use
  always_comb begin
    total  = {1'b0, hi2_r, 16'b0} + {17'b0, lo2_r} + 67'h0_8000_0000;
    q_bin  = total[66:32];
    q_last = 35'(last2_r);
    if (neg2_r) begin
      k_bin = '0;
    end else if (q_bin > q_last) begin
      k_bin = last2_r;
    end else begin
      k_bin = q_bin[AW-1:0];
    end
    k32 = 32'(k_bin);
  end

  always_comb begin
    push                = v2_r;
    push_ctl.op         = op2_r;
    push_ctl.ignored    = ign2_r;
    push_ctl.zero_count = 1'b0;
    push_ctl.res_bin    = '0;
    push_addr           = '0;
    unique case (op2_r)
      OP_SAMPLE: begin
        push_ctl.res_bin = k32[7:0];
        push_addr        = k_bin;
      end
      OP_READ: begin
        push_ctl.res_bin    = rb2_r;
        push_ctl.zero_count = zc2_r;
        push_addr           = raddr2_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: src/hdh_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Histogram item queue
// Short first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module hdh_queue #(
  parameter int W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic [W-1:0]               pop_data,
  output logic                       empty,
  output logic [hdh_pkg::QCNT_W-1:0] count
);
  import hdh_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [W-1:0]      slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign empty    = count_r == '0;
  assign count    = count_r;

  `HDH_ASSERT(a_no_overflow, !(push && !pop && count_r == QCNT_W'(QUEUE_DEPTH)), "queue overflow")
  `HDH_ASSERT(a_no_underflow, !(pop && count_r == '0), "queue underflow")

endmodule

FILE: src/hdh_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Histogram back end
// Counter memory with read-modify-write, write forwarding, clearing sweep
// and the registered result strobe.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module hdh_back #(
  parameter int BINS = hdh_pkg::BINS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  hdh_pkg::hdh_ctl_t       q_ctl,
  input  logic [$clog2(BINS)-1:0] q_addr,
  output logic                    pop,
  output logic                    init_busy,
  output logic                    out_valid,
  output logic [7:0]              out_result_bin,
  output logic [31:0]             out_result_count,
  output logic                    out_was_ignored
);
  import hdh_pkg::*;

  localparam int AW = $clog2(BINS);

  logic [31:0]   mem [BINS];

  hdh_bk_state_t state_r, state_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;

  logic          vb_r;
  hdh_ctl_t      ctl_b_r;
  logic [AW-1:0] addr_b_r;
  logic [31:0]   rd_data_r;

  logic          fwd_v_r, fwd_v_nxt;
  logic [AW-1:0] fwd_addr_r, fwd_addr_nxt;
  logic [31:0]   fwd_data_r, fwd_data_nxt;

  logic          out_valid_r;
  logic [7:0]    out_bin_r, out_bin_nxt;
  logic [31:0]   out_count_r, out_count_nxt;
  logic          out_ign_r;

  logic [31:0]   old_count;
  logic [31:0]   new_count;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  always_comb begin
    old_count = (fwd_v_r && fwd_addr_r == addr_b_r) ? fwd_data_r : rd_data_r;
    new_count = (old_count == COUNT_MAX) ? old_count : old_count + 32'd1;
  end

  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    pop          = 1'b0;
    we           = 1'b0;
    wa           = addr_b_r;
    wd           = new_count;
    fwd_v_nxt    = fwd_v_r;
    fwd_addr_nxt = fwd_addr_r;
    fwd_data_nxt = fwd_data_r;
    unique case (state_r)
      BK_INIT, BK_CLEAR: begin
        we        = 1'b1;
        wa        = sweep_r;
        wd        = '0;
        fwd_v_nxt = 1'b0;
        if (sweep_r == AW'(BINS - 1)) begin
          sweep_nxt = '0;
          state_nxt = BK_RUN;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      BK_RUN: begin
        pop = !q_empty && !(vb_r && ctl_b_r.op == OP_CLEAR);
        if (vb_r && ctl_b_r.op == OP_SAMPLE) begin
          we           = 1'b1;
          fwd_v_nxt    = 1'b1;
          fwd_addr_nxt = addr_b_r;
          fwd_data_nxt = new_count;
        end
        if (vb_r && ctl_b_r.op == OP_CLEAR) begin
          state_nxt = BK_CLEAR;
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_INIT;
      sweep_r <= '0;
      vb_r    <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      vb_r    <= pop;
      fwd_v_r <= fwd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= fwd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
    if (pop) begin
      ctl_b_r  <= q_ctl;
      addr_b_r <= q_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[q_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_comb begin
    out_bin_nxt = ctl_b_r.res_bin;
    case (ctl_b_r.op)
      OP_SAMPLE: out_count_nxt = new_count;
      OP_READ:   out_count_nxt = ctl_b_r.zero_count ? '0 : old_count;
      default:   out_count_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vb_r) begin
      out_bin_r   <= out_bin_nxt;
      out_count_r <= out_count_nxt;
      out_ign_r   <= ctl_b_r.ignored;
    end
  end

  assign init_busy        = state_r == BK_INIT;
  assign out_valid        = out_valid_r;
  assign out_result_bin   = out_bin_r;
  assign out_result_count = out_count_r;
  assign out_was_ignored  = out_ign_r;

  `HDH_ASSERT_NEXT(a_clear_starts_sweep, vb_r && ctl_b_r.op == OP_CLEAR, state_r == BK_CLEAR, "clear did not start sweep")
  `HDH_ASSERT_NEXT(a_item_gives_result, vb_r, out_valid_r, "item lost before result")
  `HDH_ASSERT_NEXT(a_sample_count_nonzero, vb_r && ctl_b_r.op == OP_SAMPLE, out_count_r != '0, "sample count is zero")

endmodule

FILE: src/height_difference_histogram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Height difference histogram
// Bins top minus bottom height differences into clamped fixed-width bins,
// with clear and read commands on the same item channel.
//
//   channel  | ports                           | handshake
//   ---------+---------------------------------+-------------------------------
//   input    | start, busy, in_*               | taken when start and not busy
//   result   | out_valid, out_*                | one-cycle strobe, no stall
//   config   | cfg_we, cfg_index, cfg_wdata    | written when cfg_we is high
//
// Sustained rate is one item per cycle outside memory clears; the counter
// read-modify-write in the back end, with one forwarded write, sets it. Each
// item passes two front stages, the queue, counter read and result registers.
// A clear sweeps the counter memory to zero; busy rises once four
// items wait in the queue and the two front stages behind it.
// After reset busy stays high during the memory clear; results cannot be held off.
// ---------------------------------------------------------------------------
module height_difference_histogram #(
  parameter int BINS = hdh_pkg::BINS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_top_height,
  input  logic signed [31:0] in_bottom_height,
  input  logic [7:0]         in_read_bin,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output logic [7:0]         out_result_bin,
  output logic [31:0]        out_result_count,
  output logic               out_was_ignored
);
  import hdh_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int QW = $bits(hdh_ctl_t) + AW;

  logic              accept;
  logic              front_full;
  logic              init_busy;
  logic              push;
  hdh_ctl_t          push_ctl;
  logic [AW-1:0]     push_addr;
  logic [QW-1:0]     push_data;
  logic              pop;
  logic [QW-1:0]     pop_data;
  hdh_ctl_t          q_ctl;
  logic [AW-1:0]     q_addr;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  assign busy      = front_full || init_busy;
  assign accept    = start && !busy;
  assign push_data = {push_ctl, push_addr};
  assign q_ctl     = pop_data[QW-1:AW];
  assign q_addr    = pop_data[AW-1:0];

  hdh_front #(
    .BINS(BINS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_command       (in_command),
    .in_top_height    (in_top_height),
    .in_bottom_height (in_bottom_height),
    .in_read_bin      (in_read_bin),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .q_count          (q_count),
    .full             (front_full),
    .push             (push),
    .push_ctl         (push_ctl),
    .push_addr        (push_addr)
  );

  hdh_queue #(
    .W(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  hdh_back #(
    .BINS(BINS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_ctl            (q_ctl),
    .q_addr           (q_addr),
    .pop              (pop),
    .init_busy        (init_busy),
    .out_valid        (out_valid),
    .out_result_bin   (out_result_bin),
    .out_result_count (out_result_count),
    .out_was_ignored  (out_was_ignored)
  );

endmodule

FILE: tb/tb_height_difference_histogram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Height difference histogram testbench
// Drives sample, clear, read and unused commands through the start/busy
// channel under a series of bin count, zero height and bin scale settings.
// A scoreboard keeps its own copy of the bin counters and the settings,
// predicts the result of every accepted item and compares each result
// strobe against the oldest prediction. A short directed part covers
// rounding at half a bin, clamping at both ends, disabled counting, bin
// count saturation and zero scale; random phases follow, with random
// sender gaps and stretches without gaps.
// ---------------------------------------------------------------------------
module tb_height_difference_histogram;
  import hdh_pkg::*;

  localparam int BINS = BINS_DEFAULT;
  localparam int LIMIT = 1_000_000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  class bin_tally;
    typedef struct packed {
      logic [7:0]  bin;
      logic [31:0] count;
      logic        ignored;
    } tally_t;

    logic [31:0]        counts [BINS];
    logic [8:0]         bin_count;
    logic signed [31:0] zero_height;
    logic [31:0]        bin_scale;
    tally_t             pending [$];
    int                 errors;

    function new();
      foreach (counts[i]) counts[i] = '0;
      bin_count   = '0;
      zero_height = '0;
      bin_scale   = SCALE_RESET;
      errors      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_BIN_COUNT:   bin_count = val[8:0];
        REG_ZERO_HEIGHT: zero_height = val;
        REG_BIN_SCALE:   bin_scale = val;
        default: ;
      endcase
    endfunction

    function int pick_bin(logic signed [31:0] top, logic signed [31:0] bottom, int n);
      logic signed [34:0] diff;
      logic [67:0]        prod;
      diff = 35'(top) - 35'(bottom) - 35'(zero_height);
      if (diff < 0) return 0;
      prod = 68'($unsigned(diff));
      prod = prod * 68'(bin_scale) + 68'h8000_0000;
      prod = prod >> 32;
      if (prod > 68'(n - 1)) return n - 1;
      return int'(prod);
    endfunction

    function void take_item(hdh_op_t op, logic signed [31:0] top,
                            logic signed [31:0] bottom, logic [7:0] rbin);
      tally_t want;
      int     n;
      int     k;
      want = '0;
      case (op)
        OP_SAMPLE: begin
          n = (int'(bin_count) > BINS) ? BINS : int'(bin_count);
          if (n <= 1) begin
            want.ignored = 1'b1;
          end else begin
            k = pick_bin(top, bottom, n);
            if (counts[k] != COUNT_MAX) counts[k] = counts[k] + 1;
            want.bin   = k[7:0];
            want.count = counts[k];
          end
        end
        OP_CLEAR: begin
          foreach (counts[i]) counts[i] = '0;
        end
        OP_READ: begin
          want.bin = rbin;
          if (int'(rbin) < BINS) want.count = counts[rbin];
        end
        default: ;
      endcase
      pending.push_back(want);
    endfunction

    function void check_result(logic [7:0] bin, logic [31:0] count, logic ignored);
      tally_t want;
      if (pending.size() == 0) begin
        errors++;
        $error("result with no item pending: bin %0d count %0d", bin, count);
        return;
      end
      want = pending.pop_front();
      if (bin !== want.bin) begin
        errors++;
        $error("result_bin: expected %0d, actual %0d", want.bin, bin);
      end
      if (count !== want.count) begin
        errors++;
        $error("result_count: expected %0d, actual %0d", want.count, count);
      end
      if (ignored !== want.ignored) begin
        errors++;
        $error("was_ignored: expected %0d, actual %0d", want.ignored, ignored);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_command = CMD_SAMPLE;
  logic signed [31:0] in_top_height = '0;
  logic signed [31:0] in_bottom_height = '0;
  logic [7:0]         in_read_bin = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_BIN_COUNT;
  logic [31:0]        cfg_wdata = '0;
  logic               out_valid;
  logic [7:0]         out_result_bin;
  logic [31:0]        out_result_count;
  logic               out_was_ignored;

  bin_tally tally;
  int       gap_max = 12;

  height_difference_histogram #(.BINS(BINS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_top_height    (in_top_height),
    .in_bottom_height (in_bottom_height),
    .in_read_bin      (in_read_bin),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_result_bin   (out_result_bin),
    .out_result_count (out_result_count),
    .out_was_ignored  (out_was_ignored)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      tally.check_result(out_result_bin, out_result_count, out_was_ignored);
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("height_difference_histogram test failed");
    $finish;
  end

  task automatic send_item(hdh_op_t op, logic signed [31:0] top,
                           logic signed [31:0] bottom, logic [7:0] rbin);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_command       <= op;
    in_top_height    <= top;
    in_bottom_height <= bottom;
    in_read_bin      <= rbin;
    do @(posedge clk); while (busy !== 1'b0);
    tally.take_item(op, top, bottom, rbin);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tally.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [8:0] bc, logic [31:0] zh, logic [31:0] sc);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    idx = '{REG_BIN_COUNT, REG_ZERO_HEIGHT, REG_BIN_SCALE};
    val = '{{23'd0, bc}, zh, sc};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      tally.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [8:0]         bc;
    logic [31:0]        zh;
    logic [31:0]        sc;
    logic signed [31:0] top;
    logic signed [31:0] bottom;
    logic [7:0]         rbin;
    hdh_op_t            op;
    longint             span;
    longint             off;
    int                 nb;
    int                 r;

    tally = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unit bin width, sixteen bins
    set_config(9'd16, 32'd0, SCALE_RESET);
    send_item(OP_SAMPLE, 32'sd0, 32'sd0, 8'($urandom));
    send_item(OP_SAMPLE, 32'sh0000_8000, 32'sd0, 8'($urandom));
    send_item(OP_SAMPLE, 32'sh0000_7FFF, 32'sd0, 8'($urandom));
    send_item(OP_SAMPLE, -3 * ONE, 32'sd0, 8'($urandom));
    send_item(OP_SAMPLE, 100 * ONE, 32'sd0, 8'($urandom));
    send_item(OP_SAMPLE, 32'sh7FFF_FFFF, 32'sh8000_0000, 8'($urandom));
    send_item(OP_SAMPLE, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'($urandom));
    send_item(OP_SAMPLE, 5 * ONE + 32'sh8000, 2 * ONE, 8'($urandom));
    send_item(OP_READ, $urandom, $urandom, 8'd1);
    send_item(OP_READ, $urandom, $urandom, 8'd4);
    send_item(OP_READ, $urandom, $urandom, 8'd15);
    send_item(OP_READ, $urandom, $urandom, 8'd255);
    send_item(OP_NOP, $urandom, $urandom, 8'($urandom));
    send_item(OP_CLEAR, $urandom, $urandom, 8'($urandom));
    send_item(OP_READ, $urandom, $urandom, 8'd15);
    send_item(OP_SAMPLE, 7 * ONE, 2 * ONE, 8'($urandom));
    send_item(OP_READ, $urandom, $urandom, 8'd5);
    drain();

    // counting disabled; reads still return stored counts
    set_config(9'd1, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, $urandom, $urandom, 8'($urandom));
    send_item(OP_READ, $urandom, $urandom, 8'd5);
    drain();
    set_config(9'd0, 32'h7FFF_FFFF, 32'd0);
    send_item(OP_SAMPLE, $urandom, $urandom, 8'($urandom));
    drain();

    // bin count above the bin depth saturates
    set_config(9'd511, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 32'sd0, 32'sd0, 8'($urandom));
    send_item(OP_READ, $urandom, $urandom, 8'd255);
    drain();

    // zero scale maps every difference to bin zero
    set_config(9'd3, 32'd0, 32'd0);
    send_item(OP_SAMPLE, 1000 * ONE, 32'sd0, 8'($urandom));
    send_item(OP_READ, $urandom, $urandom, 8'd0);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      case ($urandom_range(0, 9))
        0:       bc = 9'($urandom_range(0, 1));
        1:       bc = 9'd511;
        2:       bc = 9'd256;
        3:       bc = 9'd2;
        default: bc = 9'($urandom_range(2, 64));
      endcase
      case ($urandom_range(0, 5))
        0:       zh = 32'h8000_0000;
        1:       zh = 32'h7FFF_FFFF;
        2:       zh = $urandom;
        default: zh = 32'($urandom_range(0, 1048576)) - 32'd524288;
      endcase
      case ($urandom_range(0, 5))
        0:       sc = 32'd0;
        1:       sc = 32'hFFFF_FFFF;
        2:       sc = $urandom;
        default: sc = $urandom_range(32'd4096, 32'd1048576);
      endcase
      gap_max = (phase % 2 == 1) ? 0 : 12;
      set_config(bc, zh, sc);
      nb = (int'(bc) > BINS) ? BINS : int'(bc);
      if (sc == 0) begin
        span = 64'h7FFF_FFFF;
      end else begin
        span = (longint'(nb + 2) << 32) / longint'(sc);
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      end

      for (int i = 0; i < 100; i++) begin
        top    = $urandom;
        bottom = $urandom;
        rbin   = 8'($urandom);
        r      = $urandom_range(0, 99);
        if (r < 65) begin
          op = OP_SAMPLE;
          if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1) == 0) begin
              bottom = 32'($urandom_range(0, 1048576)) - 32'sd524288;
            end
            off = longint'($urandom_range(0, 32'(span + span / 8))) - span / 8;
            top = bottom + zh + 32'(off);
          end
        end else if (r < 88) begin
          op = OP_READ;
          if (nb > 0 && $urandom_range(0, 3) != 0) rbin = 8'($urandom_range(0, nb - 1));
        end else if (r < 94) begin
          op = OP_CLEAR;
        end else begin
          op = OP_NOP;
        end
        send_item(op, top, bottom, rbin);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (tally.errors == 0 && tally.pending.size() == 0) begin
      $display("height_difference_histogram test passed");
    end else begin
      $display("height_difference_histogram test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/hdh_pkg.sv
src/hdh_front.sv
src/hdh_queue.sv
src/hdh_back.sv
src/height_difference_histogram.sv
tb/tb_height_difference_histogram.sv
